// ----- hw/rtl/binomial_3x3_downsample_by_two_core_assert.svh -----
`ifndef BINOMIAL_3X3_DOWNSAMPLE_BY_TWO_CORE_ASSERT_SVH
`define BINOMIAL_3X3_DOWNSAMPLE_BY_TWO_CORE_ASSERT_SVH

// property must never hold outside reset
`define BD2_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BD2_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/bd2_pkg.sv -----
package bd2_pkg;

   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int LANES = 4;
   localparam int PIX_W = 8;
   localparam int VSUM_W = 10;
   localparam int TOT_W = 12;
   localparam int DATA_W = LANES * PIX_W;
   localparam int PART_W = LANES * VSUM_W;
   localparam int CFG_WIDTH_W = 12;
   localparam int CFG_HEIGHT_W = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_ADDR_W = 1;
   localparam int CMD_DEPTH = 4;
   localparam int RES_DEPTH = 4;

   localparam logic [CSR_ADDR_W-1:0] REG_IN_WIDTH = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_IN_HEIGHT = 1'd1;

   localparam logic [CFG_WIDTH_W-1:0] IN_WIDTH_RESET = 12'd640;
   localparam logic [CFG_HEIGHT_W-1:0] IN_HEIGHT_RESET = 16'd480;

   typedef struct packed {
      logic [DATA_W-1:0] pix;
      logic row_odd;
      logic emit_row;
      logic col_zero;
      logic col_odd;
      logic col_last;
      logic row_last;
   } cmd_type;

   typedef struct packed {
      logic [DATA_W-1:0] pix;
      logic eol;
      logic eof;
   } res_type;

endpackage

// ----- hw/rtl/binomial_3x3_downsample_by_two_core.sv -----
// channel   dir  handshake              payload
// req_      in   req_tvalid/req_tready  tdata: alpha, red, green, blue
// rsp_      out  rsp_tvalid/rsp_tready  tdata: alpha, red, green, blue; tlast: eol; tuser: eof
// csr_      in   csr_we                 csr_addr 0 width, 1 height; csr_wdata
//
// one pixel per cycle sustained unless rsp stalls
// latency is set by the command queue, the line store read (registered) and the result queue
// reset is synchronous and clears counters, queues and column sums; no clearing pass
// rsp stalls back up through the result queue and command queue to req_tready
`include "binomial_3x3_downsample_by_two_core_assert.svh"

module binomial_3x3_downsample_by_two_core #(
   parameter int MaxWidth = bd2_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [bd2_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [bd2_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // alpha_in, red_in, green_in, blue_in
   input  logic [bd2_pkg::DATA_W-1:0]      req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // alpha_out, red_out, green_out, blue_out
   output logic [bd2_pkg::DATA_W-1:0]      rsp_tdata,
   output logic                            rsp_tlast,
   // end_of_frame
   output logic                            rsp_tuser
);

   localparam int ColW = $clog2(MaxWidth);
   localparam int CmdW = $bits(bd2_pkg::cmd_type) + ColW;
   localparam int ResW = $bits(bd2_pkg::res_type);
   localparam int CmdCntW = $clog2(bd2_pkg::CMD_DEPTH + 1);
   localparam int ResCntW = $clog2(bd2_pkg::RES_DEPTH + 1);

   bd2_pkg::cmd_type front_cmd, back_cmd;
   logic [ColW-1:0] front_col, back_col;
   logic cmd_push, cmd_pop, cmd_empty, cmd_full;
   logic [CmdCntW-1:0] cmd_count;
   logic [CmdW-1:0] cmd_rd;

   bd2_pkg::res_type back_res, out_res;
   logic res_push, res_pop, res_empty, res_full;
   logic [ResCntW-1:0] res_count;
   logic [ResW-1:0] res_rd;

   bd2_front #(.MaxWidth(MaxWidth)) u_front (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .cmd_full(cmd_full),
      .cmd_push(cmd_push),
      .cmd(front_cmd),
      .cmd_col(front_col)
   );

   bd2_fifo #(.Width(CmdW), .Depth(bd2_pkg::CMD_DEPTH)) u_cmd_q (
      .clock(clock),
      .reset(reset),
      .push(cmd_push),
      .push_data({front_col, front_cmd}),
      .pop(cmd_pop),
      .pop_data(cmd_rd),
      .empty(cmd_empty),
      .full(cmd_full),
      .count(cmd_count)
   );

   assign back_cmd = bd2_pkg::cmd_type'(cmd_rd[$bits(bd2_pkg::cmd_type)-1:0]);
   assign back_col = cmd_rd[CmdW-1:$bits(bd2_pkg::cmd_type)];

   bd2_back #(.MaxWidth(MaxWidth), .ResDepth(bd2_pkg::RES_DEPTH)) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_empty(cmd_empty),
      .cmd(back_cmd),
      .cmd_col(back_col),
      .cmd_pop(cmd_pop),
      .res_count(res_count),
      .res_push(res_push),
      .res(back_res)
   );

   bd2_fifo #(.Width(ResW), .Depth(bd2_pkg::RES_DEPTH)) u_res_q (
      .clock(clock),
      .reset(reset),
      .push(res_push),
      .push_data(back_res),
      .pop(res_pop),
      .pop_data(res_rd),
      .empty(res_empty),
      .full(res_full),
      .count(res_count)
   );

   assign out_res = bd2_pkg::res_type'(res_rd);
   assign rsp_tvalid = !res_empty;
   assign res_pop = rsp_tvalid && rsp_tready;
   assign rsp_tdata = out_res.pix;
   assign rsp_tlast = out_res.eol;
   assign rsp_tuser = out_res.eof;

   `BD2_ASSERT_IMPLIES(a_eof_has_eol, rsp_tvalid && rsp_tuser, rsp_tlast, "eof without eol")
   `BD2_ASSERT_NEVER(a_res_overflow, res_push && res_full && !res_pop, "result queue overflow")
   `BD2_ASSERT_NEVER(a_cmd_pop_empty, cmd_pop && (cmd_count == '0), "command queue underflow")

endmodule

// ----- hw/rtl/bd2_ram.sv -----
module bd2_ram #(
   parameter int Width = 32,
   parameter int Depth = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/bd2_fifo.sv -----
module bd2_fifo #(
   parameter int Width = 8,
   parameter int Depth = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [Width-1:0]           push_data,
   input  logic                       pop,
   output logic [Width-1:0]           pop_data,
   output logic                       empty,
   output logic                       full,
   output logic [$clog2(Depth+1)-1:0] count
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

   logic [Width-1:0] mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full = (count_ff == CntW'(Depth));
   assign count = count_ff;

endmodule

// ----- hw/rtl/bd2_front.sv -----
module bd2_front #(
   parameter int MaxWidth = bd2_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [bd2_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [bd2_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bd2_pkg::DATA_W-1:0]      req_tdata,
   input  logic                            cmd_full,
   output logic                            cmd_push,
   output bd2_pkg::cmd_type                cmd,
   output logic [$clog2(MaxWidth)-1:0]     cmd_col
);

   localparam int ColW = $clog2(MaxWidth);
   localparam int CmpW = (ColW + 1 > bd2_pkg::CFG_WIDTH_W) ? ColW + 1 : bd2_pkg::CFG_WIDTH_W;
   localparam int RowW = bd2_pkg::CFG_HEIGHT_W;
   localparam logic [CmpW-1:0] MaxW = CmpW'(MaxWidth);

   logic [bd2_pkg::CFG_WIDTH_W-1:0] in_width_ff, in_width_in;
   logic [RowW-1:0] in_height_ff, in_height_in;
   logic [ColW-1:0] col_ff, col_in;
   logic [RowW-1:0] row_ff, row_in;

   logic [CmpW-1:0] w_raw, w_eff;
   logic [RowW-1:0] h_eff;
   logic [CmpW-1:0] col_ext;
   logic [ColW-1:0] c;
   logic [RowW-1:0] r;
   logic col_last, row_last, accept;

   always_comb begin
      w_raw = CmpW'(in_width_ff);
      if (w_raw == '0) begin
         w_eff = CmpW'(1);
      end else if (w_raw > MaxW) begin
         w_eff = MaxW;
      end else begin
         w_eff = w_raw;
      end
      h_eff = (in_height_ff == '0) ? RowW'(1) : in_height_ff;
      col_ext = CmpW'(col_ff);
      c = (col_ext >= w_eff) ? '0 : col_ff;
      r = (row_ff >= h_eff) ? '0 : row_ff;
      col_last = (CmpW'(c) == w_eff - 1'b1);
      row_last = (r == h_eff - 1'b1);
   end

   assign req_tready = !cmd_full;
   assign accept = req_tvalid && !cmd_full;

   always_comb begin
      in_width_in = in_width_ff;
      in_height_in = in_height_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (csr_we) begin
         case (csr_addr)
            bd2_pkg::REG_IN_WIDTH: in_width_in = csr_wdata[bd2_pkg::CFG_WIDTH_W-1:0];
            bd2_pkg::REG_IN_HEIGHT: in_height_in = csr_wdata[RowW-1:0];
            default: ;
         endcase
      end
      if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : r + 1'b1;
         end else begin
            col_in = c + 1'b1;
            row_in = r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff <= bd2_pkg::IN_WIDTH_RESET;
         in_height_ff <= bd2_pkg::IN_HEIGHT_RESET;
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         in_width_ff <= in_width_in;
         in_height_ff <= in_height_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_comb begin
      cmd.pix = req_tdata;
      cmd.row_odd = r[0];
      cmd.emit_row = (!r[0] && (|r[RowW-1:1])) || (r[0] && row_last);
      cmd.col_zero = (c == '0);
      cmd.col_odd = c[0];
      cmd.col_last = col_last;
      cmd.row_last = row_last;
   end

   assign cmd_push = accept;
   assign cmd_col = c;

endmodule

// ----- hw/rtl/bd2_back.sv -----
module bd2_back #(
   parameter int MaxWidth = bd2_pkg::MAX_WIDTH_DEFAULT,
   parameter int ResDepth = bd2_pkg::RES_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_empty,
   input  bd2_pkg::cmd_type                cmd,
   input  logic [$clog2(MaxWidth)-1:0]     cmd_col,
   output logic                            cmd_pop,
   input  logic [$clog2(ResDepth+1)-1:0]   res_count,
   output logic                            res_push,
   output bd2_pkg::res_type                res
);

   localparam int ColW = $clog2(MaxWidth);
   localparam int CntW = $clog2(ResDepth + 1);
   localparam int PW = bd2_pkg::PIX_W;
   localparam int VW = bd2_pkg::VSUM_W;
   localparam int TW = bd2_pkg::TOT_W;

   logic s1_v_ff, s1_v_in;
   bd2_pkg::cmd_type s1_cmd_ff, s1_cmd_in;
   logic [ColW-1:0] s1_col_ff, s1_col_in;
   logic [bd2_pkg::PART_W-1:0] left_ff, left_in;
   logic [bd2_pkg::PART_W-1:0] mid_ff, mid_in;

   logic [bd2_pkg::DATA_W-1:0] top_rd;
   logic [bd2_pkg::PART_W-1:0] part_rd, part_wd, vcol;
   logic [bd2_pkg::DATA_W-1:0] out_pix;
   logic top_we, part_we, emit;

   assign cmd_pop = !cmd_empty && ((CntW + 1)'(res_count) + (CntW + 1)'(s1_v_ff)
                    < (CntW + 1)'(ResDepth));

   bd2_ram #(.Width(bd2_pkg::DATA_W), .Depth(MaxWidth)) u_top_row (
      .clock(clock),
      .we(top_we),
      .waddr(s1_col_ff),
      .wdata(s1_cmd_ff.pix),
      .re(cmd_pop),
      .raddr(cmd_col),
      .rdata(top_rd)
   );

   bd2_ram #(.Width(bd2_pkg::PART_W), .Depth(MaxWidth)) u_partial_col (
      .clock(clock),
      .we(part_we),
      .waddr(s1_col_ff),
      .wdata(part_wd),
      .re(cmd_pop),
      .raddr(cmd_col),
      .rdata(part_rd)
   );

   assign top_we = s1_v_ff && !s1_cmd_ff.row_odd;
   assign part_we = s1_v_ff && s1_cmd_ff.row_odd;

   always_comb begin
      logic [PW-1:0] t, x;
      logic [VW-1:0] p, l, m, v;
      logic [TW-1:0] s;
      for (int ch = 0; ch < bd2_pkg::LANES; ch++) begin
         t = top_rd[PW*ch +: PW];
         x = s1_cmd_ff.pix[PW*ch +: PW];
         p = part_rd[VW*ch +: VW];
         part_wd[VW*ch +: VW] = VW'(t) + {1'b0, x, 1'b0};
         v = s1_cmd_ff.row_odd ? (VW'(t) + {1'b0, x, 1'b0} + VW'(x)) : (p + VW'(x));
         vcol[VW*ch +: VW] = v;
         l = left_ff[VW*ch +: VW];
         m = mid_ff[VW*ch +: VW];
         if (s1_cmd_ff.col_odd) begin
            s = TW'(l) + {1'b0, v, 1'b0} + TW'(v);
         end else begin
            s = TW'(l) + {1'b0, m, 1'b0} + TW'(v);
         end
         out_pix[PW*ch +: PW] = s[TW-1:TW-PW];
      end
   end

   assign emit = s1_v_ff && s1_cmd_ff.emit_row && !s1_cmd_ff.col_zero
                 && (!s1_cmd_ff.col_odd || s1_cmd_ff.col_last);

   always_comb begin
      s1_v_in = cmd_pop;
      s1_cmd_in = cmd_pop ? cmd : s1_cmd_ff;
      s1_col_in = cmd_pop ? cmd_col : s1_col_ff;
      left_in = left_ff;
      mid_in = mid_ff;
      if (s1_v_ff && s1_cmd_ff.emit_row) begin
         if (s1_cmd_ff.col_zero) begin
            left_in = vcol;
         end else if (s1_cmd_ff.col_odd) begin
            mid_in = vcol;
         end else begin
            left_in = vcol;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         left_ff <= '0;
         mid_ff <= '0;
      end else begin
         s1_v_ff <= s1_v_in;
         left_ff <= left_in;
         mid_ff <= mid_in;
      end
      s1_cmd_ff <= s1_cmd_in;
      s1_col_ff <= s1_col_in;
   end

   assign res_push = emit;
   assign res.pix = out_pix;
   assign res.eol = s1_cmd_ff.col_last;
   assign res.eof = s1_cmd_ff.col_last && s1_cmd_ff.row_last;

endmodule
